/* design/rc4_pkg.sv */
// Shared constants, operation codes and interface structs for the RC4 block.
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_DEPTH   = 256;

  localparam int BYTE_W = 8;
  localparam int TBL_AW = $clog2(TABLE_DEPTH);
  localparam int KEY_AW = $clog2(KEY_DEPTH);
  localparam int KCNT_W = $clog2(KEY_DEPTH + 1);
  localparam int LEN_W  = 9;
  localparam int DIV_W  = 10;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SCHED = 2'd1,
    OP_CRYPT = 2'd2
  } op_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } mod_req_t;

  typedef struct packed {
    logic              clear;
    logic [KEY_AW-1:0] raddr;
  } key_ctl_t;

endpackage

/* design/rc4_mod_unit.sv */
// Modulo unit: reduces a sum modulo the active table length.
`timescale 1ns / 1ps

module rc4_mod_unit
  import rc4_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mod_req_t          req,
  input  logic [LEN_W-1:0]  len,
  output logic              busy,
  output logic [TBL_AW-1:0] rem
);

  localparam int STEPS = DIV_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [LEN_W-1:0] part;
  logic [DIV_W-1:0] shreg;
  logic [CNT_W-1:0] cnt;
  logic             fast;
  logic [DIV_W-1:0] len_ext;
  logic [DIV_W-1:0] fast_val;
  logic [LEN_W-1:0] r1;
  logic [LEN_W-1:0] r2;

  function automatic logic [LEN_W-1:0] mod_step(input logic [LEN_W-1:0] r, input logic b,
                                                input logic [LEN_W-1:0] n);
    logic [LEN_W:0] s;
    s = {r, b};
    if (s >= {1'b0, n}) begin
      mod_step = LEN_W'(s - {1'b0, n});
    end else begin
      mod_step = s[LEN_W-1:0];
    end
  endfunction

  // A sum below twice the length needs at most one subtraction.
  assign len_ext  = DIV_W'(len);
  assign fast     = req.dividend < {len, 1'b0};
  assign fast_val = (req.dividend >= len_ext) ? (req.dividend - len_ext) : req.dividend;

  // Otherwise a restoring reduction runs two dividend bits per cycle.
  assign r1 = mod_step(part, shreg[DIV_W-1], len);
  assign r2 = mod_step(r1, shreg[DIV_W-2], len);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      if (fast) begin
        rem  <= fast_val[TBL_AW-1:0];
        busy <= 1'b0;
      end else begin
        busy  <= 1'b1;
        part  <= '0;
        shreg <= req.dividend;
        cnt   <= '0;
      end
    end else if (busy) begin
      part  <= r2;
      shreg <= shreg << 2;
      cnt   <= cnt + 1'b1;
      if (cnt == CNT_W'(STEPS - 1)) begin
        rem  <= r2[TBL_AW-1:0];
        busy <= 1'b0;
      end
    end
  end

endmodule

/* design/rc4_key_store.sv */
// Key byte memory with its fill count.
`timescale 1ns / 1ps

module rc4_key_store
  import rc4_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [BYTE_W-1:0] load_data,
  input  key_ctl_t          ctl,
  output logic [BYTE_W-1:0] rd_data,
  output logic [KCNT_W-1:0] count
);

  logic [BYTE_W-1:0] key_mem [KEY_DEPTH];
  logic              has_room;

  // Bytes past the end of the store are dropped.
  assign has_room = count < KCNT_W'(KEY_DEPTH);

  always_ff @(posedge clk) begin
    if (load && has_room) begin
      key_mem[count[KEY_AW-1:0]] <= load_data;
    end
    rd_data <= key_mem[ctl.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clear) begin
      count <= '0;
    end else if (load && has_room) begin
      count <= count + 1'b1;
    end
  end

endmodule

/* design/rc4_core.sv */
// Sequencer and permutation memory for key scheduling and keystream generation.
`timescale 1ns / 1ps

module rc4_core
  import rc4_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start_sched,
  input  logic              start_crypt,
  input  logic [BYTE_W-1:0] data,
  input  logic [LEN_W-1:0]  len,
  input  logic [BYTE_W-1:0] key_data,
  input  logic [KCNT_W-1:0] key_count,
  output key_ctl_t          key_ctl,
  output logic              busy,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic [BYTE_W-1:0] stream_byte
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_SH_RD,
    ST_SH_SUM,
    ST_SH_BW,
    ST_SH_SB,
    ST_SH_WB,
    ST_E_I,
    ST_E_IW,
    ST_E_SI,
    ST_E_JW,
    ST_E_SJ,
    ST_E_WJ,
    ST_E_TW,
    ST_E_OUT
  } state_t;

  state_t state;

  logic [BYTE_W-1:0] perm_mem [TABLE_DEPTH];
  logic              mem_we;
  logic [TBL_AW-1:0] mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [TBL_AW-1:0] mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  logic [TBL_AW-1:0] a;
  logic [TBL_AW-1:0] b;
  logic [KEY_AW-1:0] k;
  logic [TBL_AW-1:0] last;
  logic              fill_sched;
  logic [BYTE_W-1:0] sa;
  logic [TBL_AW-1:0] i;
  logic [TBL_AW-1:0] j;
  logic [BYTE_W-1:0] si;
  logic [BYTE_W-1:0] data_q;
  logic [BYTE_W-1:0] kb;

  mod_req_t          mod_req;
  logic              mod_busy;
  logic [TBL_AW-1:0] mod_rem;

  rc4_mod_unit u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mod_req),
    .len  (len),
    .busy (mod_busy),
    .rem  (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      perm_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= perm_mem[mem_raddr];
  end

  // An empty key behaves as one zero byte.
  assign kb   = (key_count != '0) ? key_data : '0;
  assign busy = (state != ST_IDLE);

  always_comb begin
    mem_we           = 1'b0;
    mem_waddr        = a;
    mem_wdata        = mem_rdata;
    mem_raddr        = a;
    mod_req.start    = 1'b0;
    mod_req.dividend = '0;
    key_ctl.clear    = 1'b0;
    key_ctl.raddr    = k;
    unique case (state)
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = BYTE_W'(a);
      end
      ST_SH_SUM: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = DIV_W'(b) + DIV_W'(mem_rdata) + DIV_W'(kb);
      end
      ST_SH_BW: mem_raddr = mod_rem;
      ST_SH_SB: begin
        mem_we    = 1'b1;
        mem_waddr = a;
        mem_wdata = mem_rdata;
      end
      ST_SH_WB: begin
        mem_we        = 1'b1;
        mem_waddr     = b;
        mem_wdata     = sa;
        key_ctl.clear = (a == last);
      end
      ST_E_I: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = DIV_W'(i) + DIV_W'(1);
      end
      ST_E_IW: mem_raddr = mod_rem;
      ST_E_SI: begin
        mod_req.start    = 1'b1;
        mod_req.dividend = DIV_W'(j) + DIV_W'(mem_rdata);
      end
      ST_E_JW: mem_raddr = mod_rem;
      ST_E_SJ: begin
        mem_we           = 1'b1;
        mem_waddr        = i;
        mem_wdata        = mem_rdata;
        mod_req.start    = 1'b1;
        mod_req.dividend = DIV_W'(si) + DIV_W'(mem_rdata);
      end
      ST_E_WJ: begin
        mem_we    = 1'b1;
        mem_waddr = j;
        mem_wdata = si;
      end
      ST_E_TW: mem_raddr = mod_rem;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // Reset refills the whole table with the identity.
      state       <= ST_FILL;
      a           <= '0;
      last        <= TBL_AW'(TABLE_DEPTH - 1);
      fill_sched  <= 1'b0;
      i           <= '0;
      j           <= '0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start_sched) begin
            a          <= '0;
            last       <= TBL_AW'(len - 1'b1);
            fill_sched <= 1'b1;
            state      <= ST_FILL;
          end else if (start_crypt) begin
            data_q <= data;
            state  <= ST_E_I;
          end
        end
        ST_FILL: begin
          if (a == last) begin
            a     <= '0;
            b     <= '0;
            k     <= '0;
            state <= fill_sched ? ST_SH_RD : ST_IDLE;
          end else begin
            a <= a + 1'b1;
          end
        end
        ST_SH_RD:  state <= ST_SH_SUM;
        ST_SH_SUM: begin
          sa    <= mem_rdata;
          state <= ST_SH_BW;
        end
        ST_SH_BW: begin
          if (!mod_busy) begin
            b     <= mod_rem;
            state <= ST_SH_SB;
          end
        end
        ST_SH_SB:  state <= ST_SH_WB;
        ST_SH_WB: begin
          if (a == last) begin
            i     <= '0;
            j     <= '0;
            state <= ST_IDLE;
          end else begin
            a     <= a + 1'b1;
            k     <= ((KCNT_W'(k) + 1'b1) == key_count) ? '0 : k + 1'b1;
            state <= ST_SH_RD;
          end
        end
        ST_E_I:  state <= ST_E_IW;
        ST_E_IW: begin
          if (!mod_busy) begin
            i     <= mod_rem;
            state <= ST_E_SI;
          end
        end
        ST_E_SI: begin
          si    <= mem_rdata;
          state <= ST_E_JW;
        end
        ST_E_JW: begin
          if (!mod_busy) begin
            j     <= mod_rem;
            state <= ST_E_SJ;
          end
        end
        ST_E_SJ: state <= ST_E_WJ;
        ST_E_WJ: state <= ST_E_TW;
        ST_E_TW: begin
          if (!mod_busy) begin
            state <= ST_E_OUT;
          end
        end
        ST_E_OUT: begin
          out_valid   <= 1'b1;
          out_byte    <= data_q ^ mem_rdata;
          stream_byte <= mem_rdata;
          state       <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/rc4_stream_cipher.sv */
// RC4 stream cipher top level: length register, command decode and submodules.
// Key load: taken without raising busy. Encrypt: the result beat comes after the index
// updates, the swap and the lookup; a slow-path modulo reduction stalls it. Schedule:
// identity fill of L entries, then a swap per entry, via one read and one write port.
// Reset: synchronous; after it a pass over all 256 entries restores the identity table,
// busy high. Results are strobed for one cycle; the receiver cannot stall them.
`timescale 1ns / 1ps

module rc4_stream_cipher
  import rc4_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op,
  input  logic [BYTE_W-1:0] data,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_data,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic [BYTE_W-1:0] stream_byte
);

  // The length register; the effective length clamps it to 1..TABLE_DEPTH.
  logic [LEN_W-1:0] state_len;
  logic [LEN_W-1:0] eff_len;

  logic accept;
  logic load_key;
  logic start_sched;
  logic start_crypt;

  key_ctl_t          key_ctl;
  logic [BYTE_W-1:0] key_data;
  logic [KCNT_W-1:0] key_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_len <= LEN_W'(256);
    end else if (cfg_we) begin
      state_len <= cfg_data;
    end
  end

  always_comb begin
    priority if (state_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (state_len > LEN_W'(TABLE_DEPTH)) begin
      eff_len = LEN_W'(TABLE_DEPTH);
    end else begin
      eff_len = state_len;
    end
  end

  // A command beat is taken when start meets an idle block. The unused op code
  // is accepted and does nothing.
  assign accept      = start && !busy;
  assign load_key    = accept && (op == OP_LOAD);
  assign start_sched = accept && (op == OP_SCHED);
  assign start_crypt = accept && (op == OP_CRYPT);

  rc4_key_store u_key (
    .clk       (clk),
    .rst       (rst),
    .load      (load_key),
    .load_data (data),
    .ctl       (key_ctl),
    .rd_data   (key_data),
    .count     (key_count)
  );

  rc4_core u_core (
    .clk         (clk),
    .rst         (rst),
    .start_sched (start_sched),
    .start_crypt (start_crypt),
    .data        (data),
    .len         (eff_len),
    .key_data    (key_data),
    .key_count   (key_count),
    .key_ctl     (key_ctl),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .stream_byte (stream_byte)
  );

endmodule

/* test/rc4_stream_cipher_tb.sv */
// Self-checking testbench for the RC4 stream cipher: directed table, random key/encrypt runs.
`timescale 1ns / 1ps

module rc4_stream_cipher_tb;
  import rc4_pkg::*;

  localparam int RESET_CYCLES  = 9;
  // This covers any command, such as a schedule at full size, that is still running
  // when the last result beat has arrived.
  localparam int SETTLE_CYCLES = 3000;
  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int RANDOM_ITEMS  = 110;
  localparam int NUM_PHASES    = 11;
  localparam int MAX_REPORTS   = 10;

  // Op code 3 has no meaning; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table. For ROW_CFG, value is the length register.
  // For ROW_ITEM, value[7:0] is the data byte, incremented on each repeat.
  typedef struct packed {
    row_kind_t         kind;
    logic [1:0]        op;
    logic [LEN_W-1:0]  value;
    logic [8:0]        reps;
    logic              typed;
    logic [BYTE_W-1:0] exp_out;
    logic [BYTE_W-1:0] exp_ks;
  } stim_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_b;
    logic [BYTE_W-1:0] ks;
  } beat_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              start    = 1'b0;
  logic              busy;
  logic [1:0]        op       = 2'd0;
  logic [BYTE_W-1:0] data     = '0;
  logic              cfg_we   = 1'b0;
  logic [LEN_W-1:0]  cfg_data = '0;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic [BYTE_W-1:0] stream_byte;

  // Shadow state of the cipher.
  logic [BYTE_W-1:0] perm_tab [TABLE_DEPTH];
  logic [BYTE_W-1:0] key_mem  [KEY_DEPTH];
  int                key_cnt;
  int                idx_i;
  int                idx_j;
  logic [LEN_W-1:0]  len_reg;

  beat_t pending_beats [$];
  int    fail_count  = 0;
  int    cycle_count = 0;
  int    idle_pct    = 0;

  // Expected results are typed in only where they follow directly from the
  // identity table after reset or from a one-entry table.
  stim_row_t directed_rows [26] = '{
    '{ROW_ITEM, OP_CRYPT,  9'h000, 9'd1,   1'b1, 8'h02, 8'h02},  // before any schedule
    '{ROW_ITEM, OP_CRYPT,  9'h0ff, 9'd1,   1'b1, 8'hfa, 8'h05},
    '{ROW_ITEM, OP_UNUSED, 9'h0a5, 9'd1,   1'b0, 8'h00, 8'h00},  // must change nothing
    '{ROW_ITEM, OP_CRYPT,  9'h000, 9'd1,   1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, OP_SCHED,  9'h000, 9'd1,   1'b0, 8'h00, 8'h00},  // empty key
    '{ROW_ITEM, OP_CRYPT,  9'h05a, 9'd2,   1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, OP_LOAD,   9'h000, 9'd1,   1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, OP_LOAD,   9'h0ff, 9'd1,   1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, OP_LOAD,   9'h001, 9'd1,   1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, OP_SCHED,  9'h1ff, 9'd1,   1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, OP_CRYPT,  9'h000, 9'd1,   1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, OP_CRYPT,  9'h0ff, 9'd1,   1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, OP_CRYPT,  9'h080, 9'd3,   1'b0, 8'h00, 8'h00},
    '{ROW_CFG,  OP_LOAD,   9'd1,   9'd1,   1'b0, 8'h00, 8'h00},  // smallest table
    '{ROW_ITEM, OP_SCHED,  9'h000, 9'd1,   1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, OP_CRYPT,  9'h03c, 9'd1,   1'b1, 8'h3c, 8'h00},
    '{ROW_CFG,  OP_LOAD,   9'd0,   9'd1,   1'b0, 8'h00, 8'h00},  // zero acts as one
    '{ROW_ITEM, OP_CRYPT,  9'h0c3, 9'd1,   1'b1, 8'hc3, 8'h00},
    '{ROW_CFG,  OP_LOAD,   9'd511, 9'd1,   1'b0, 8'h00, 8'h00},  // clamps to full size
    '{ROW_ITEM, OP_CRYPT,  9'h011, 9'd3,   1'b0, 8'h00, 8'h00},
    '{ROW_CFG,  OP_LOAD,   9'd256, 9'd1,   1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, OP_LOAD,   9'h010, 9'd260, 1'b0, 8'h00, 8'h00},  // key overflow
    '{ROW_ITEM, OP_SCHED,  9'h000, 9'd1,   1'b0, 8'h00, 8'h00},
    '{ROW_ITEM, OP_CRYPT,  9'h0e7, 9'd4,   1'b0, 8'h00, 8'h00},
    '{ROW_CFG,  OP_LOAD,   9'd5,   9'd1,   1'b0, 8'h00, 8'h00},  // shrink without schedule
    '{ROW_ITEM, OP_CRYPT,  9'h042, 9'd4,   1'b0, 8'h00, 8'h00}
  };

  rc4_stream_cipher i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .data        (data),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .stream_byte (stream_byte)
  );

  always #6 clk = ~clk;

  function automatic int table_size();
    int n;
    n = int'(len_reg);
    if (n < 1) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  function automatic void swap_perm(input int a, input int b);
    logic [BYTE_W-1:0] tmp;
    tmp         = perm_tab[a];
    perm_tab[a] = perm_tab[b];
    perm_tab[b] = tmp;
  endfunction

  // Only the first n entries are rebuilt; the rest keep their old contents.
  function automatic void key_schedule();
    int n;
    int a;
    int b;
    int kb;
    n = table_size();
    b = 0;
    for (a = 0; a < n; a++) perm_tab[a] = a[BYTE_W-1:0];
    for (a = 0; a < n; a++) begin
      kb = 0;
      if (key_cnt != 0) kb = int'(key_mem[(a % key_cnt) % KEY_DEPTH]);
      b = (b + int'(perm_tab[a]) + kb) % n;
      swap_perm(a, b);
    end
    key_cnt = 0;
    idx_i   = 0;
    idx_j   = 0;
  endfunction

  function automatic beat_t cipher_step(input logic [BYTE_W-1:0] plain);
    int    n;
    int    t;
    beat_t res;
    n     = table_size();
    idx_i = (idx_i + 1) % n;
    idx_j = (idx_j + int'(perm_tab[idx_i])) % n;
    swap_perm(idx_i, idx_j);
    t      = (int'(perm_tab[idx_i]) + int'(perm_tab[idx_j])) % n;
    res.ks = perm_tab[t];
    res.out_b = plain ^ res.ks;
    return res;
  endfunction

  // Called at the edge where a command beat is taken.
  function automatic void accept_item(input logic [1:0] item_op,
                                      input logic [BYTE_W-1:0] item_data,
                                      input logic typed,
                                      input logic [BYTE_W-1:0] exp_out,
                                      input logic [BYTE_W-1:0] exp_ks);
    beat_t want;
    case (item_op)
      OP_LOAD: begin
        if (key_cnt < KEY_DEPTH) begin
          key_mem[key_cnt] = item_data;
          key_cnt++;
        end
      end
      OP_SCHED: key_schedule();
      OP_CRYPT: begin
        want = cipher_step(item_data);
        if (typed) begin
          want.out_b = exp_out;
          want.ks    = exp_ks;
        end
        pending_beats = {pending_beats, want};
      end
      default: ;
    endcase
  endfunction

  // Before each beat the sender holds start low with probability idle_pct,
  // drawn again every cycle. Otherwise start stays high from one beat to the
  // next, so back-to-back key loads are taken on consecutive edges.
  task automatic send_item(input logic [1:0] item_op, input logic [BYTE_W-1:0] item_data,
                           input logic typed, input logic [BYTE_W-1:0] exp_out,
                           input logic [BYTE_W-1:0] exp_ks);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op    <= item_op;
    data  <= item_data;
    @(posedge clk);
    while (busy) @(posedge clk);
    accept_item(item_op, item_data, typed, exp_out, exp_ks);
  endtask

  // The length register is only written with the block drained and idle.
  task automatic write_len(input logic [LEN_W-1:0] value);
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    len_reg = value;
  endtask

  // Mostly well-formed key/schedule/encrypt sequences with random content;
  // the rest is raw noise including the unused op code.
  task automatic run_phase(input logic [LEN_W-1:0] len_value, input int quota);
    int         sent;
    int         klen;
    int         ncrypt;
    int         k;
    logic [1:0] rop;
    write_len(len_value);
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 99) < 85) begin
        klen = $urandom_range(0, 8);
        for (k = 0; k < klen; k++)
          send_item(OP_LOAD, 8'($urandom_range(0, 255)), 1'b0, 8'h00, 8'h00);
        send_item(OP_SCHED, 8'($urandom_range(0, 255)), 1'b0, 8'h00, 8'h00);
        ncrypt = $urandom_range(2, 10);
        for (k = 0; k < ncrypt; k++)
          send_item(OP_CRYPT, 8'($urandom_range(0, 255)), 1'b0, 8'h00, 8'h00);
        sent += klen + 1 + ncrypt;
      end else begin
        repeat ($urandom_range(3, 10)) begin
          rop = 2'($urandom_range(0, 3));
          send_item(rop, 8'($urandom_range(0, 255)), 1'b0, 8'h00, 8'h00);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin : check_beats
    beat_t want;
    if (!rst && out_valid) begin
      if (pending_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result beat: out_byte=%02h stream_byte=%02h",
                   out_byte, stream_byte);
      end else begin
        want = pending_beats.pop_front();
        if (out_byte !== want.out_b || stream_byte !== want.ks) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("beat mismatch: expected out_byte=%02h stream_byte=%02h, got %02h %02h",
                     want.out_b, want.ks, out_byte, stream_byte);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [LEN_W-1:0] phase_lens [NUM_PHASES];
    int               r;
    int               k;
    int               p;
    phase_lens = '{9'd256, 9'd2, 9'd1, 9'd16, 9'd0, 9'd255, 9'd300, 9'd7, 9'd511, 9'd3, 9'd0};
    phase_lens[NUM_PHASES-1] = 9'($urandom_range(4, 40));

    for (k = 0; k < TABLE_DEPTH; k++) perm_tab[k] = k[BYTE_W-1:0];
    for (k = 0; k < KEY_DEPTH; k++) key_mem[k] = '0;
    key_cnt = 0;
    idx_i   = 0;
    idx_j   = 0;
    len_reg = 9'd256;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Encrypts right after reset see the identity table.
    for (r = 0; r < $size(directed_rows); r++) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_len(directed_rows[r].value);
      end else begin
        for (k = 0; k < int'(directed_rows[r].reps); k++)
          send_item(directed_rows[r].op, directed_rows[r].value[BYTE_W-1:0] + k[BYTE_W-1:0],
                    directed_rows[r].typed, directed_rows[r].exp_out, directed_rows[r].exp_ks);
      end
    end

    // Random phases: no gaps, frequent gaps, occasional gaps, in rotation.
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 58;
        default: idle_pct = 14;
      endcase
      run_phase(phase_lens[p], RANDOM_ITEMS / NUM_PHASES);
    end

    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
